### rtl/core/cgsm_pkg.sv
// Package for the cued glitch sample mixer: item structs, opcodes, register indexes,
// reset values and the mix arithmetic. Depends on nothing.
package cgsm_pkg;

  typedef enum logic [1:0] {
    OP_PROCESS     = 2'd0,
    OP_LOAD_SAMPLE = 2'd1,
    OP_LOAD_CUE    = 2'd2
  } op_e;

  localparam logic [7:0] REG_VOLUME        = 8'd0;
  localparam logic [7:0] REG_SAMPLE_LENGTH = 8'd1;
  localparam logic [7:0] REG_CUE_COUNT     = 8'd2;
  localparam logic [7:0] REG_PLAY_LENGTH   = 8'd3;

  localparam logic [15:0] VOLUME_RST        = 16'd16384;
  localparam logic [16:0] SAMPLE_LENGTH_RST = 17'd1;
  localparam logic [6:0]  CUE_COUNT_RST     = 7'd0;
  localparam logic [19:0] PLAY_LENGTH_RST   = 20'd4096;

  // Dividend width of the shared remainder unit: (time >> 8) is 24 bits.
  localparam int DIV_W   = 24;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        address;
    logic [31:0]        time_now;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               is_playing;
  } out_item_t;

  // Round half up the Q2.14 product, add to the input and saturate to 16 bits.
  function automatic logic signed [15:0] mix_sat(input logic signed [15:0] din,
                                                 input logic signed [32:0] prod);
    logic [33:0]        rnd;
    logic signed [19:0] scaled;
    logic signed [20:0] sum;
    rnd    = {prod[32], prod} + 34'd8192;
    scaled = rnd[33:14];
    sum    = {{5{din[15]}}, din} + {scaled[19], scaled};
    if (sum > 21'sd32767) begin
      mix_sat = 16'sh7fff;
    end else if (sum < -21'sd32768) begin
      mix_sat = 16'sh8000;
    end else begin
      mix_sat = sum[15:0];
    end
  endfunction

endpackage

### rtl/core/cued_glitch_sample_mixer_top.sv
// Top level of the cued glitch sample mixer: sample store, cue table, scan
// sequencer, shared remainder unit and mixer. Depends on cgsm_pkg.
//
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_item_i): one item per handshake.
//     A load sample item writes one stereo frame, a load cue item writes one cue
//     time; both give no result. A process item gives exactly one result item.
//   out channel (out_valid_o / out_ready_i / out_item_o): mixed frame and the
//     playing flag after the step, held in an output register.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): always
//     ready; write registers only while no item is in flight.
// Sequencing: a load item is taken in idle and the block stays idle. A process item scans the
//   cue table from the last hit, one entry a cycle through the cue memory port; a playing tick
//   adds a 24-step remainder for the store index, the store read and two multiplies, and a
//   trigger first adds a 24-step remainder for the start offset. No new item is taken until
//   the current process item has reached the output register.
// Reset: playback stops, time, cue scan position and offset clear, registers
//   take their defaults. Both stores hold garbage until written.
// Stall: a finished result waits in the output register; the next item is still
//   accepted and processed, and its result holds until the slot frees.
module cued_glitch_sample_mixer_top #(
  parameter int SAMPLE_DEPTH = 65536,
  parameter int CUE_DEPTH    = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cgsm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cgsm_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int SW  = $clog2(SAMPLE_DEPTH);
  localparam int LW  = SW + 1;
  localparam int CW  = (CUE_DEPTH > 1) ? $clog2(CUE_DEPTH) : 1;
  localparam int CNW = $clog2(CUE_DEPTH + 1);
  localparam int DW  = cgsm_pkg::DIV_W;
  localparam int DCW = cgsm_pkg::DIV_CNT_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_DIVIDE = 8'b0000_0100,
    ST_PLAY   = 8'b0000_1000,
    ST_RDS    = 8'b0001_0000,
    ST_MULL   = 8'b0010_0000,
    ST_MULR   = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_e;

  // Configuration registers
  logic [15:0] cfg_vol_q;
  logic [16:0] cfg_len_q;
  logic [6:0]  cfg_cue_q;
  logic [19:0] cfg_plen_q;

  // Control and datapath registers
  state_e              state_q, state_d;
  cgsm_pkg::in_item_t  item_q, item_d;
  logic [31:0]         last_q, last_d;
  logic                playing_q, playing_d;
  logic [19:0]         pos_q, pos_d;
  logic [SW-1:0]       ofs_q, ofs_d;
  logic [CW-1:0]       scan_q, scan_d;
  logic [CNW-1:0]      rd_idx_q, rd_idx_d;
  logic [CW-1:0]       cmp_idx_q, cmp_idx_d;
  logic                pend_q, pend_d;
  logic [DW-1:0]       num_q, num_d;
  logic [LW-1:0]       rem_q, rem_d;
  logic [DCW-1:0]      div_cnt_q, div_cnt_d;
  logic                div_idx_q, div_idx_d;
  logic signed [32:0]  prod_q, prod_d;
  logic signed [15:0]  res_l_q, res_l_d;
  logic signed [15:0]  res_r_q, res_r_d;
  logic                res_play_q, res_play_d;
  logic                out_valid_q, out_valid_d;
  cgsm_pkg::out_item_t out_item_q, out_item_d;

  // Memories
  logic [31:0] smp_mem [SAMPLE_DEPTH];
  logic [31:0] cue_mem [CUE_DEPTH];
  logic [31:0] smp_rdata_q;
  logic [31:0] cue_rdata_q;

  logic        in_acc;
  logic        cue_rd_en;
  logic        cue_hit;
  logic [31:0] addr_ext;
  logic [31:0] len_ext;
  logic [31:0] cue_ext;
  logic [LW-1:0]  len_eff;
  logic [CNW-1:0] count_eff;
  logic [LW:0]    div_trial;
  logic [LW:0]    div_diff;
  logic [LW-1:0]  rem_next;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign addr_ext    = 32'(in_item_i.address);
  assign len_ext     = 32'(cfg_len_q);
  assign cue_ext     = 32'(cfg_cue_q);

  // Clamp the register values to what the stores hold.
  always_comb begin
    if (cfg_len_q == 17'd0) begin
      len_eff = LW'(1);
    end else if (len_ext > 32'(SAMPLE_DEPTH)) begin
      len_eff = LW'(SAMPLE_DEPTH);
    end else begin
      len_eff = LW'(cfg_len_q);
    end
    if (cue_ext > 32'(CUE_DEPTH)) begin
      count_eff = CNW'(CUE_DEPTH);
    end else begin
      count_eff = CNW'(cfg_cue_q);
    end
  end

  // One restoring step of the remainder unit: shift in a dividend bit, subtract if it fits.
  assign div_trial = {rem_q, num_q[DW-1]};
  assign div_diff  = div_trial - {1'b0, len_eff};
  assign rem_next  = (div_trial >= {1'b0, len_eff}) ? div_diff[LW-1:0] : div_trial[LW-1:0];

  // Cue data read in the previous cycle is compared against (last time, now].
  assign cue_hit = pend_q && (last_q < cue_rdata_q) && (cue_rdata_q <= item_q.time_now);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    last_d      = last_q;
    playing_d   = playing_q;
    pos_d       = pos_q;
    ofs_d       = ofs_q;
    scan_d      = scan_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    pend_d      = pend_q;
    num_d       = num_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    div_idx_d   = div_idx_q;
    prod_d      = prod_q;
    res_l_d     = res_l_q;
    res_r_d     = res_r_q;
    res_play_d  = res_play_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    cue_rd_en   = 1'b0;

    // Drop the result once the receiver takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d = in_item_i;
          if (in_item_i.opcode == cgsm_pkg::OP_PROCESS) begin
            rd_idx_d = CNW'(scan_q);
            pend_d   = 1'b0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pend_d = 1'b0;
        if (cue_hit) begin
          scan_d = cmp_idx_q;
          last_d = item_q.time_now;
          if (!playing_q) begin
            // Trigger: start playback, work out the start offset first.
            playing_d = 1'b1;
            pos_d     = 20'd0;
            num_d     = item_q.time_now[31:8];
            rem_d     = '0;
            div_cnt_d = '0;
            div_idx_d = 1'b0;
            state_d   = ST_DIVIDE;
          end else begin
            state_d = ST_PLAY;
          end
        end else if (rd_idx_q < count_eff) begin
          cue_rd_en = 1'b1;
          pend_d    = 1'b1;
          cmp_idx_d = rd_idx_q[CW-1:0];
          rd_idx_d  = rd_idx_q + CNW'(1);
        end else begin
          last_d  = item_q.time_now;
          state_d = ST_PLAY;
        end
      end
      ST_DIVIDE: begin
        num_d     = num_q << 1;
        rem_d     = rem_next;
        div_cnt_d = div_cnt_q + DCW'(1);
        if (div_cnt_q == DCW'(DW - 1)) begin
          if (div_idx_q) begin
            state_d = ST_RDS;
          end else begin
            ofs_d   = rem_next[SW-1:0];
            state_d = ST_PLAY;
          end
        end
      end
      ST_PLAY: begin
        res_l_d    = item_q.left_in;
        res_r_d    = item_q.right_in;
        res_play_d = 1'b0;
        if (playing_q) begin
          if (pos_q >= cfg_plen_q) begin
            playing_d = 1'b0;
            pos_d     = 20'd0;
            state_d   = ST_FIN;
          end else begin
            num_d     = DW'(pos_q) + DW'(ofs_q);
            rem_d     = '0;
            div_cnt_d = '0;
            div_idx_d = 1'b1;
            pos_d     = pos_q + 20'd1;
            state_d   = ST_DIVIDE;
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_RDS: begin
        state_d = ST_MULL;
      end
      ST_MULL: begin
        prod_d  = $signed({1'b0, cfg_vol_q}) * $signed(smp_rdata_q[31:16]);
        state_d = ST_MULR;
      end
      ST_MULR: begin
        prod_d  = $signed({1'b0, cfg_vol_q}) * $signed(smp_rdata_q[15:0]);
        res_l_d = cgsm_pkg::mix_sat(item_q.left_in, prod_q);
        state_d = ST_FIN;
        // Right channel still pending: mark it so FIN finishes it first.
        res_play_d = 1'b1;
        div_idx_d  = 1'b1;
      end
      ST_FIN: begin
        if (res_play_q && div_idx_q) begin
          // Finish the right channel from the product held over from MULR.
          res_r_d   = cgsm_pkg::mix_sat(item_q.right_in, prod_q);
          div_idx_d = 1'b0;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_item_d.left_out   = res_l_q;
          out_item_d.right_out  = res_r_q;
          out_item_d.is_playing = res_play_q;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Configuration writes are to land only while idle; the user is bound, the block does not enforce it.
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cgsm_pkg::REG_VOLUME,
        cgsm_pkg::REG_SAMPLE_LENGTH,
        cgsm_pkg::REG_CUE_COUNT,
        cgsm_pkg::REG_PLAY_LENGTH: ;
        default: ;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_vol_q  <= cgsm_pkg::VOLUME_RST;
      cfg_len_q  <= cgsm_pkg::SAMPLE_LENGTH_RST;
      cfg_cue_q  <= cgsm_pkg::CUE_COUNT_RST;
      cfg_plen_q <= cgsm_pkg::PLAY_LENGTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cgsm_pkg::REG_VOLUME:        cfg_vol_q  <= cfg_data_i[15:0];
        cgsm_pkg::REG_SAMPLE_LENGTH: cfg_len_q  <= cfg_data_i[16:0];
        cgsm_pkg::REG_CUE_COUNT:     cfg_cue_q  <= cfg_data_i[6:0];
        cgsm_pkg::REG_PLAY_LENGTH:   cfg_plen_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 32'd0;
      playing_q   <= 1'b0;
      pos_q       <= 20'd0;
      ofs_q       <= '0;
      scan_q      <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      div_cnt_q   <= '0;
      div_idx_q   <= 1'b0;
      res_play_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      playing_q   <= playing_d;
      pos_q       <= pos_d;
      ofs_q       <= ofs_d;
      scan_q      <= scan_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      div_cnt_q   <= div_cnt_d;
      div_idx_q   <= div_idx_d;
      res_play_q  <= res_play_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    cmp_idx_q  <= cmp_idx_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    prod_q     <= prod_d;
    res_l_q    <= res_l_d;
    res_r_q    <= res_r_d;
    out_item_q <= out_item_d;
  end

  // Sample store: write on frame loads, registered read of the playback index.
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_item_i.opcode == cgsm_pkg::OP_LOAD_SAMPLE) &&
        (addr_ext < 32'(SAMPLE_DEPTH))) begin
      smp_mem[addr_ext[SW-1:0]] <= {in_item_i.left_in, in_item_i.right_in};
    end
    if (state_q == ST_RDS) begin
      smp_rdata_q <= smp_mem[rem_q[SW-1:0]];
    end
  end

  // Cue table: write on cue loads, registered read during the scan.
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_item_i.opcode == cgsm_pkg::OP_LOAD_CUE) &&
        (addr_ext < 32'(CUE_DEPTH))) begin
      cue_mem[addr_ext[CW-1:0]] <= in_item_i.time_now;
    end
    if (cue_rd_en) begin
      cue_rdata_q <= cue_mem[rd_idx_q[CW-1:0]];
    end
  end

`ifndef SYNTHESIS
  // Load items and unused opcodes never leave idle.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.opcode != cgsm_pkg::OP_PROCESS)) |=> (state_q == ST_IDLE))
    else $error("load item left the idle state");

  // Position is cleared whenever playback is off.
  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !playing_q |-> (pos_q == 20'd0))
    else $error("play position nonzero while not playing");

  // The remainder unit ends below the effective length.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIVIDE) && (div_cnt_q == DCW'(DW - 1))) |=> (rem_q < len_eff))
    else $error("remainder not below sample length");

  // A cue hit lies within the valid cue entries.
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && cue_hit) |-> (CNW'(cmp_idx_q) < count_eff))
    else $error("cue hit beyond cue count");

  // A result only appears from the finish state.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside finish state");
`endif

endmodule
